// ----- sv/lbp_pkg.sv -----
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the LED blink pattern generator.
// ----------------------------------------------------------------------------
package lbp_pkg;

  // Configuration register widths and indexes
  localparam int CFG_WIDTH = 24;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_QUICK_HALF = 2'd0,
    CFG_SLOW_HALF  = 2'd1,
    CFG_PULSE_HALF = 2'd2,
    CFG_PAUSE      = 2'd3
  } cfg_index_t;

  // Reset values of the configuration registers (microseconds)
  localparam logic [CFG_WIDTH-1:0] QUICK_HALF_RESET = 24'd60000;
  localparam logic [CFG_WIDTH-1:0] SLOW_HALF_RESET  = 24'd1200000;
  localparam logic [CFG_WIDTH-1:0] PULSE_HALF_RESET = 24'd120000;
  localparam logic [CFG_WIDTH-1:0] PAUSE_RESET      = 24'd1500000;

  // Field widths
  localparam int MODE_WIDTH   = 5;
  localparam int ON_WIDTH     = 24;
  localparam int OFF_WIDTH    = 29;
  localparam int PERIOD_WIDTH = 32;

  // Period used while the indicator is off
  localparam logic [PERIOD_WIDTH-1:0] OFF_PERIOD_US = 32'hFFFF_FFFF;

  // Mode codes
  localparam logic signed [MODE_WIDTH-1:0] MODE_STEADY_ON = -5'sd1;

  // LED commands
  typedef enum logic [1:0] {
    LED_OFF    = 2'd0,
    LED_ON     = 2'd1,
    LED_TOGGLE = 2'd2
  } led_cmd_t;

  // Per-mode timing of one registered poll
  typedef struct packed {
    logic signed [MODE_WIDTH-1:0] mode;
    logic [ON_WIDTH-1:0]          on_us;
    logic [OFF_WIDTH-1:0]         off_us;
    logic [PERIOD_WIDTH-1:0]      period_us;
  } lbp_times_t;

endpackage

// ----- sv/lbp_timing.sv -----
// ----------------------------------------------------------------------------
// lbp_timing
// Configuration registers and input stage: registers each poll together
// with the on, off and period times of its requested mode.
// ----------------------------------------------------------------------------
module lbp_timing #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [lbp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [lbp_pkg::CFG_WIDTH-1:0]         cfg_wdata,
  input  logic                                  in_load,
  input  logic [TIME_WIDTH-1:0]                 now_us,
  input  logic signed [lbp_pkg::MODE_WIDTH-1:0] mode,
  input  logic                                  advance,
  output logic                                  a_valid,
  output logic [TIME_WIDTH-1:0]                 a_now,
  output lbp_pkg::lbp_times_t                   a_times
);
  import lbp_pkg::*;

  logic [CFG_WIDTH-1:0] quick_half;
  logic [CFG_WIDTH-1:0] slow_half;
  logic [CFG_WIDTH-1:0] pulse_half;
  logic [CFG_WIDTH-1:0] pause;
  lbp_times_t           times_next;
  logic [OFF_WIDTH-1:0] counted_off;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      quick_half <= QUICK_HALF_RESET;
      slow_half  <= SLOW_HALF_RESET;
      pulse_half <= PULSE_HALF_RESET;
      pause      <= PAUSE_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_QUICK_HALF: quick_half <= cfg_wdata;
        CFG_SLOW_HALF:  slow_half  <= cfg_wdata;
        CFG_PULSE_HALF: pulse_half <= cfg_wdata;
        CFG_PAUSE:      pause      <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Counted flashes: off time is 2*N pulse half periods
  assign counted_off = OFF_WIDTH'(pulse_half) * OFF_WIDTH'({mode[3:0], 1'b0});

  // Per-mode times
  always_comb begin
    times_next.mode = mode;
    if (mode < MODE_STEADY_ON) begin
      times_next.on_us     = '0;
      times_next.off_us    = '0;
      times_next.period_us = OFF_PERIOD_US;
    end else if (mode == MODE_STEADY_ON) begin
      times_next.on_us     = '0;
      times_next.off_us    = '0;
      times_next.period_us = '0;
    end else if (mode[4:1] == 4'd0) begin
      times_next.on_us     = mode[0] ? slow_half : quick_half;
      times_next.off_us    = OFF_WIDTH'(times_next.on_us);
      times_next.period_us = PERIOD_WIDTH'({times_next.on_us, 1'b0});
    end else begin
      times_next.on_us     = pulse_half;
      times_next.off_us    = counted_off;
      times_next.period_us = PERIOD_WIDTH'(counted_off) + PERIOD_WIDTH'(pause);
    end
  end

  // Input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_load || (a_valid && !advance);
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (in_load) begin
      a_now   <= now_us;
      a_times <= times_next;
    end
  end

endmodule

// ----- sv/lbp_decide.sv -----
// ----------------------------------------------------------------------------
// lbp_decide
// Pattern state and command decision: compares the poll time with the phase
// start and last toggle, updates the state and registers the command.
// ----------------------------------------------------------------------------
module lbp_decide #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  a_valid,
  input  logic [TIME_WIDTH-1:0] a_now,
  input  lbp_pkg::lbp_times_t   a_times,
  input  logic                  out_stall,
  output logic                  advance,
  output logic                  out_valid,
  output logic [1:0]            led_command
);
  import lbp_pkg::*;

  // Sum width holds any base plus any duration without wrapping
  localparam int SUM_WIDTH = ((TIME_WIDTH > PERIOD_WIDTH) ? TIME_WIDTH : PERIOD_WIDTH) + 1;

  logic signed [MODE_WIDTH-1:0] active_mode;
  logic [TIME_WIDTH-1:0]        phase_start;
  logic [TIME_WIDTH-1:0]        last_toggle;

  logic [SUM_WIDTH-1:0] now_ext;
  logic [SUM_WIDTH-1:0] period_end;
  logic [SUM_WIDTH-1:0] off_end;
  logic [SUM_WIDTH-1:0] on_end;
  logic                 changed;
  logic                 fire;
  logic                 set_phase;
  logic                 set_toggle;
  led_cmd_t             cmd;

  assign advance = !out_valid || !out_stall;

  // Deadlines; a sum past the time range is never reached
  assign now_ext    = SUM_WIDTH'(a_now);
  assign period_end = SUM_WIDTH'(phase_start) + SUM_WIDTH'(a_times.period_us);
  assign off_end    = SUM_WIDTH'(phase_start) + SUM_WIDTH'(a_times.off_us);
  assign on_end     = SUM_WIDTH'(last_toggle) + SUM_WIDTH'(a_times.on_us);
  assign changed    = (a_times.mode != active_mode);

  // Command selection; a mode change restarts the phase and emits nothing
  always_comb begin
    fire       = 1'b0;
    set_phase  = 1'b0;
    set_toggle = 1'b0;
    cmd        = LED_OFF;
    priority if (changed) begin
      set_phase  = 1'b1;
      set_toggle = 1'b1;
    end else if (now_ext > period_end) begin
      fire       = 1'b1;
      cmd        = LED_ON;
      set_phase  = 1'b1;
      set_toggle = 1'b1;
    end else if (now_ext > off_end) begin
      fire = 1'b1;
      cmd  = LED_OFF;
    end else if (now_ext > on_end) begin
      fire       = 1'b1;
      cmd        = LED_TOGGLE;
      set_toggle = 1'b1;
    end else begin
      fire = 1'b0;
    end
  end

  // Pattern state
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode <= '0;
      phase_start <= '0;
      last_toggle <= '0;
    end else if (a_valid && advance) begin
      active_mode <= a_times.mode;
      if (set_phase) begin
        phase_start <= a_now;
      end
      if (set_toggle) begin
        last_toggle <= a_now;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= a_valid && fire;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      led_command <= cmd;
    end
  end

endmodule

// ----- sv/led_blink_pattern_generator.sv -----
// ----------------------------------------------------------------------------
// led_blink_pattern_generator
// Turns timed indicator polls into LED on, off and toggle commands.
// ----------------------------------------------------------------------------
// Usage:
//   Each poll on the input channel (in_valid / in_stall) carries now_us and
//   the requested mode. A poll yields zero or one command on the output
//   channel (out_valid / out_stall): 0 off, 1 on, 2 toggle.
//   A poll is first registered with the on, off and period times of its
//   mode, then compared against the phase start and last toggle times; the
//   command lands in the output register. Throughput is one poll per cycle
//   while the receiver does not stall: the input and output registers each
//   hold one transaction, and the state update settles within the single
//   decision stage, so back-to-back polls see the updated state.
//   When the receiver stalls a waiting command, one more poll is taken
//   into an empty input register, then in_stall rises until the command is
//   taken.
//   Configuration registers are written through cfg_write_en, cfg_index and
//   cfg_wdata while no poll is in flight.
//   Reset (rst, synchronous) restores the default half periods and pause,
//   clears the mode to quick flash and both timestamps to zero, and empties
//   both registers.
// ----------------------------------------------------------------------------
module led_blink_pattern_generator #(
  parameter int TIME_WIDTH = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [lbp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [lbp_pkg::CFG_WIDTH-1:0]         cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [TIME_WIDTH-1:0]                 now_us,
  input  logic signed [lbp_pkg::MODE_WIDTH-1:0] mode,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            led_command
);
  import lbp_pkg::*;

  logic                  a_valid;
  logic [TIME_WIDTH-1:0] a_now;
  lbp_times_t            a_times;
  logic                  advance;
  logic                  in_load;

  // Input stage frees up whenever its poll moves on
  assign in_stall = a_valid && !advance;
  assign in_load  = in_valid && !in_stall;

  lbp_timing #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_timing (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_load     (in_load),
    .now_us      (now_us),
    .mode        (mode),
    .advance     (advance),
    .a_valid     (a_valid),
    .a_now       (a_now),
    .a_times     (a_times)
  );

  lbp_decide #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_decide (
    .clk        (clk),
    .rst        (rst),
    .a_valid    (a_valid),
    .a_now      (a_now),
    .a_times    (a_times),
    .out_stall  (out_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .led_command(led_command)
  );

endmodule

// ----- verif/led_blink_pattern_generator_test.sv -----
// ----------------------------------------------------------------------------
// led_blink_pattern_generator_test
// Self-checking testbench for the LED blink pattern generator.
// ----------------------------------------------------------------------------
// A short directed sequence walks through every kind of mode, the bounds of
// the on, off and period times, time going backwards and timestamps near the
// top of the time range. Random polls then run under several register
// settings (reset values, tiny, zero, maximum, random, moderate), with random
// idling on both channels in all but the last. A scoreboard predicts the
// command of every poll and checks each command transaction in order.
// ----------------------------------------------------------------------------
module led_blink_pattern_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lbp_pkg::*;

  localparam int TIME_WIDTH = 48;
  localparam logic [64:0] TIME_MAX = (65'd1 << TIME_WIDTH) - 65'd1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;

  // Mode codes used by the stimulus
  localparam logic signed [MODE_WIDTH-1:0] MODE_LOWEST = -5'sd16;
  localparam logic signed [MODE_WIDTH-1:0] MODE_OFF    = -5'sd2;
  localparam logic signed [MODE_WIDTH-1:0] MODE_QUICK  = 5'sd0;
  localparam logic signed [MODE_WIDTH-1:0] MODE_SLOW   = 5'sd1;
  localparam logic signed [MODE_WIDTH-1:0] MODE_HIGHEST = 5'sd15;

  // Predicts the LED command of each poll and checks the commands in order
  class blink_scoreboard;
    logic [CFG_WIDTH-1:0] quick_us, slow_us, pulse_us, pause_len_us;
    logic signed [MODE_WIDTH-1:0] cur_mode;
    logic [TIME_WIDTH-1:0] phase_t, toggle_t;
    led_cmd_t expected_cmds[$];
    int errors;

    function new();
      quick_us = QUICK_HALF_RESET;
      slow_us = SLOW_HALF_RESET;
      pulse_us = PULSE_HALF_RESET;
      pause_len_us = PAUSE_RESET;
      cur_mode = MODE_QUICK;
      phase_t = '0;
      toggle_t = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_WIDTH-1:0] v);
      case (idx)
        CFG_QUICK_HALF: quick_us = v;
        CFG_SLOW_HALF:  slow_us = v;
        CFG_PULSE_HALF: pulse_us = v;
        CFG_PAUSE:      pause_len_us = v;
        default: ;
      endcase
    endfunction

    // t > base + d; a sum past the time range never counts as reached
    function bit exceeds(logic [TIME_WIDTH-1:0] t, logic [TIME_WIDTH-1:0] base,
                         logic [63:0] d);
      logic [64:0] sum;
      sum = 65'(base) + 65'(d);
      if (sum > TIME_MAX) return 1'b0;
      return 65'(t) > sum;
    endfunction

    function void note_poll(logic [TIME_WIDTH-1:0] t, logic signed [MODE_WIDTH-1:0] m);
      logic [63:0] on_us, off_us, period_us;
      // new mode restarts the phase
      if (m != cur_mode) begin
        cur_mode = m;
        phase_t = t;
        toggle_t = t;
      end
      if (m < -1) begin
        on_us = '0;
        off_us = '0;
        period_us = 64'(OFF_PERIOD_US);
      end else if (m == MODE_STEADY_ON) begin
        on_us = '0;
        off_us = '0;
        period_us = '0;
      end else if (m < 2) begin
        on_us = (m == MODE_SLOW) ? slow_us : quick_us;
        off_us = on_us;
        period_us = on_us << 1;
      end else begin
        on_us = pulse_us;
        off_us = on_us * 64'(2 * int'(m));
        period_us = off_us + 64'(pause_len_us);
      end
      if (exceeds(t, phase_t, period_us)) begin
        expected_cmds.push_back(LED_ON);
        phase_t = t;
        toggle_t = t;
      end else if (exceeds(t, phase_t, off_us)) begin
        expected_cmds.push_back(LED_OFF);
      end else if (exceeds(t, toggle_t, on_us)) begin
        expected_cmds.push_back(LED_TOGGLE);
        toggle_t = t;
      end
    endfunction

    function void check_command(logic [1:0] got);
      led_cmd_t want;
      if (expected_cmds.size() == 0) begin
        $error("led_command: unexpected transaction, expected none, actual %0d", got);
        errors++;
        return;
      end
      want = expected_cmds.pop_front();
      if (got !== want) begin
        $error("led_command mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TIME_WIDTH-1:0] now_us = '0;
  logic signed [MODE_WIDTH-1:0] mode = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] led_command;

  blink_scoreboard board;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  logic [TIME_WIDTH-1:0] t_now = '0;
  logic signed [MODE_WIDTH-1:0] m_now = '0;

  led_blink_pattern_generator #(.TIME_WIDTH(TIME_WIDTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now_us(now_us),
    .mode(mode),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .led_command(led_command)
  );

  always #5 clk = ~clk;

  // Receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_poll(now_us, mode);
      if (out_valid && !out_stall) board.check_command(led_command);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("** led_blink_pattern_generator: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One poll transaction; called and returns at a falling edge
  task automatic send_poll(logic [TIME_WIDTH-1:0] t, logic signed [MODE_WIDTH-1:0] m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    now_us <= t;
    mode <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending, drain all commands, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(logic [CFG_WIDTH-1:0] q, logic [CFG_WIDTH-1:0] s,
                              logic [CFG_WIDTH-1:0] p, logic [CFG_WIDTH-1:0] pa);
    logic [CFG_WIDTH-1:0] vals [4];
    vals = '{q, s, p, pa};
    for (int i = 0; i < 4; i++) begin
      cfg_write_en <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_wdata <= vals[i];
      board.write_reg(cfg_index_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_write_en <= 1'b0;
  endtask

  // Random polls: modes held for a while, time mostly stepping forward
  task automatic run_random(int count);
    int unsigned r, span, mode_pick;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        if ($urandom_range(0, 4) == 0) begin
          m_now = 5'($urandom);
        end else begin
          mode_pick = $urandom_range(0, 17);
          m_now = 5'(mode_pick) - 5'd2;
        end
      end
      if (m_now == MODE_QUICK) span = board.quick_us;
      else if (m_now == MODE_SLOW) span = board.slow_us;
      else if (m_now >= 2) span = board.pulse_us;
      else span = board.pause_len_us;
      r = $urandom_range(0, 99);
      if (r < 3) t_now = 48'({$urandom, $urandom});
      else if (r < 6) t_now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3));
      else if (r < 10) t_now = t_now - 48'($urandom_range(1, 1000));
      else if (r < 13) t_now = t_now + 48'hFFFF_FFFF + 48'($urandom_range(0, 2));
      else if (r < 20) t_now = t_now;
      else if (r < 30) t_now = t_now + 48'($urandom_range(1, 32 * span + 2));
      else t_now = t_now + 48'($urandom_range(1, 2 * span + 2));
      send_poll(t_now, m_now);
    end
  endtask

  initial begin
    logic [TIME_WIDTH-1:0] base;
    board = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 80;

    // Directed: reset timing, mode kinds, boundaries, backwards and top of range
    send_poll(48'd0, MODE_QUICK);
    send_poll(48'd60000, MODE_QUICK);
    send_poll(48'd60001, MODE_QUICK);
    send_poll(48'd120001, MODE_QUICK);
    send_poll(48'd120001, MODE_SLOW);
    send_poll(48'd1320002, MODE_SLOW);
    send_poll(48'd1320002, MODE_STEADY_ON);
    send_poll(48'd1320003, MODE_STEADY_ON);
    send_poll(48'd1320004, MODE_OFF);
    send_poll(48'd1320005, MODE_OFF);
    send_poll(48'd1320004 + 48'hFFFF_FFFF, MODE_OFF);
    send_poll(48'd1320005 + 48'hFFFF_FFFF, MODE_OFF);
    base = 48'd1320005 + 48'hFFFF_FFFF + 48'd10;
    send_poll(base, 5'sd3);
    send_poll(base + 48'd120001, 5'sd3);
    send_poll(base + 48'd120002, 5'sd3);
    send_poll(base + 48'd240002, 5'sd3);
    send_poll(base + 48'd720001, 5'sd3);
    send_poll(48'd100, 5'sd3);
    send_poll(48'd0, 5'sd2);
    send_poll(48'hFFFF_FFFF_FFFF, MODE_HIGHEST);
    send_poll(48'hFFFF_FFFF_FFFF, MODE_HIGHEST);
    send_poll(48'hFFFF_FFFF_FFFF, MODE_LOWEST);
    send_poll(48'hFFFF_FFFF_FFFF, MODE_STEADY_ON);
    send_poll(48'hFFFF_FFFF_FFFE, MODE_STEADY_ON);
    t_now = 48'd5000;
    m_now = MODE_QUICK;
    run_random(60);

    // Tiny times: frequent commands and exact boundaries
    settle();
    program_regs(24'($urandom_range(0, 3)), 24'($urandom_range(1, 8)),
                 24'($urandom_range(0, 3)), 24'($urandom_range(0, 10)));
    run_random(90);

    // All times zero
    settle();
    program_regs('0, '0, '0, '0);
    run_random(90);

    send_idle_pct = 80;
    recv_idle_pct = 26;
    // All times at their maximum
    settle();
    program_regs('1, '1, '1, '1);
    run_random(90);

    // Random full-width times
    settle();
    program_regs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    run_random(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Moderate times, no idling
    settle();
    program_regs(24'($urandom_range(1, 200)), 24'($urandom_range(1, 2000)),
                 24'($urandom_range(1, 100)), 24'($urandom_range(0, 1000)));
    run_random(90);

    settle();
    if (board.errors == 0) begin
      $display("** led_blink_pattern_generator: PASSED **");
    end else begin
      $display("** led_blink_pattern_generator: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/lbp_pkg.sv
sv/lbp_timing.sv
sv/lbp_decide.sv
sv/led_blink_pattern_generator.sv
verif/led_blink_pattern_generator_test.sv
